@@ hdl/mmc_pkg.sv @@
// Package for the magnetometer min/max calibration core.
// Holds the widths, the queue entry type and the back-end state types.
// No dependencies.
package mmc_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int GAIN_FRAC_BITS = 12;
    localparam int GAIN_BITS      = 16;

    // Range sum and 3*range both fit in two bits more than a range.
    localparam int SUM_W  = SAMPLE_BITS + 2;
    localparam int DEN_W  = SAMPLE_BITS + 2;
    localparam int NUM_W  = SUM_W + GAIN_FRAC_BITS;
    localparam int HI_W   = NUM_W - GAIN_BITS;
    localparam int CMP_W  = (HI_W > DEN_W) ? HI_W : DEN_W;
    localparam int CNT_W  = $clog2(GAIN_BITS);

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [GAIN_BITS-1:0] GAIN_MAX = {GAIN_BITS{1'b1}};

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [SAMPLE_BITS-1:0]        range_t;
    typedef logic [GAIN_BITS-1:0]          gain_t;

    typedef struct packed {
        sample_t offset_x;
        sample_t offset_y;
        sample_t offset_z;
        range_t  range_x;
        range_t  range_y;
        range_t  range_z;
    } mmc_item_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SETUP,
        B_CHECK,
        B_DIV,
        B_DONE
    } back_state_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

endpackage

@@ hdl/mmc_front.sv @@
// Front end: accepts samples, tracks per-axis peaks, forms offsets and ranges.
// Depends on mmc_pkg.
module mmc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mmc_pkg::sample_t    mag_x,
    input  mmc_pkg::sample_t    mag_y,
    input  mmc_pkg::sample_t    mag_z,
    output logic                push_valid,
    input  logic                push_ready,
    output mmc_pkg::mmc_item_t  push_item
);
    import mmc_pkg::*;

    sample_t hi_x_reg, hi_y_reg, hi_z_reg;
    sample_t lo_x_reg, lo_y_reg, lo_z_reg;
    sample_t hi_x_next, hi_y_next, hi_z_next;
    sample_t lo_x_next, lo_y_next, lo_z_next;

    logic accept;

    function automatic sample_t half_sum(sample_t hi, sample_t lo);
        logic signed [SAMPLE_BITS:0] s;
        s = {hi[SAMPLE_BITS-1], hi} + {lo[SAMPLE_BITS-1], lo};
        return s[SAMPLE_BITS:1];
    endfunction

    function automatic range_t span(sample_t hi, sample_t lo);
        logic signed [SAMPLE_BITS:0] d;
        d = {hi[SAMPLE_BITS-1], hi} - {lo[SAMPLE_BITS-1], lo};
        return d[SAMPLE_BITS-1:0];
    endfunction

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    // Widen peaks with the incoming sample
    always_comb
    begin
        hi_x_next = (mag_x > hi_x_reg) ? mag_x : hi_x_reg;
        hi_y_next = (mag_y > hi_y_reg) ? mag_y : hi_y_reg;
        hi_z_next = (mag_z > hi_z_reg) ? mag_z : hi_z_reg;
        lo_x_next = (mag_x < lo_x_reg) ? mag_x : lo_x_reg;
        lo_y_next = (mag_y < lo_y_reg) ? mag_y : lo_y_reg;
        lo_z_next = (mag_z < lo_z_reg) ? mag_z : lo_z_reg;
    end

    always_comb
    begin
        push_item.offset_x = half_sum(hi_x_next, lo_x_next);
        push_item.offset_y = half_sum(hi_y_next, lo_y_next);
        push_item.offset_z = half_sum(hi_z_next, lo_z_next);
        push_item.range_x  = span(hi_x_next, lo_x_next);
        push_item.range_y  = span(hi_y_next, lo_y_next);
        push_item.range_z  = span(hi_z_next, lo_z_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_x_reg <= '0;
            hi_y_reg <= '0;
            hi_z_reg <= '0;
            lo_x_reg <= '0;
            lo_y_reg <= '0;
            lo_z_reg <= '0;
        end
        else if (accept)
        begin
            hi_x_reg <= hi_x_next;
            hi_y_reg <= hi_y_next;
            hi_z_reg <= hi_z_next;
            lo_x_reg <= lo_x_next;
            lo_y_reg <= lo_y_next;
            lo_z_reg <= lo_z_next;
        end
    end

endmodule

@@ hdl/mmc_fifo.sv @@
// Short register queue between front and back ends.
// Depends on mmc_pkg.
module mmc_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  mmc_pkg::mmc_item_t  push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output mmc_pkg::mmc_item_t  pop_item
);
    import mmc_pkg::*;

    mmc_item_t         slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              do_push, do_pop;

    function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign push_ready = (fill_reg != FILL_W'(FIFO_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

endmodule

@@ hdl/mmc_back.sv @@
// Back end: shared restoring divider for the three soft-iron gains, output register.
// Depends on mmc_pkg.
module mmc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  mmc_pkg::mmc_item_t  pop_item,
    output logic                out_valid,
    input  logic                out_ready,
    output mmc_pkg::sample_t    offset_x,
    output mmc_pkg::sample_t    offset_y,
    output mmc_pkg::sample_t    offset_z,
    output mmc_pkg::gain_t      gain_x,
    output mmc_pkg::gain_t      gain_y,
    output mmc_pkg::gain_t      gain_z,
    output logic                gain_saturated
);
    import mmc_pkg::*;

    back_state_t       state_reg, state_next;
    axis_t             axis_reg, axis_next;
    mmc_item_t         item_reg, item_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    gain_t             quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    gain_t             gx_reg, gx_next, gy_reg, gy_next, gz_reg, gz_next;
    logic              sat_reg, sat_next;

    logic              out_valid_reg, out_valid_next;
    sample_t           ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    gain_t             ogx_reg, ogx_next, ogy_reg, ogy_next, ogz_reg, ogz_next;
    logic              osat_reg, osat_next;

    range_t            range_sel;
    logic [NUM_W-1:0]  num;
    logic [CMP_W-1:0]  hi_ext, den_ext;
    logic [DEN_W:0]    trial, trial_sub;
    logic              trial_ge;
    logic              gain_wr;
    gain_t             gain_val;
    logic              advance;

    assign num       = {sum_reg, {GAIN_FRAC_BITS{1'b0}}};
    assign hi_ext    = CMP_W'(num[NUM_W-1:GAIN_BITS]);
    assign den_ext   = CMP_W'(den_reg);
    assign trial     = {rem_reg, quo_reg[GAIN_BITS-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign trial_ge  = (trial >= {1'b0, den_reg});
    assign pop_ready = (state_reg == B_IDLE);

    always_comb
    begin
        unique case (axis_reg)
            AXIS_X:  range_sel = item_reg.range_x;
            AXIS_Y:  range_sel = item_reg.range_y;
            AXIS_Z:  range_sel = item_reg.range_z;
            default: range_sel = item_reg.range_x;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        item_next      = item_reg;
        sum_next       = sum_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        sat_next       = sat_reg;
        gain_wr        = 1'b0;
        gain_val       = quo_reg;
        advance        = 1'b0;
        out_valid_next = out_valid_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        oz_next        = oz_reg;
        ogx_next       = ogx_reg;
        ogy_next       = ogy_reg;
        ogz_next       = ogz_reg;
        osat_next      = osat_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    item_next  = pop_item;
                    sum_next   = SUM_W'(pop_item.range_x) + SUM_W'(pop_item.range_y)
                               + SUM_W'(pop_item.range_z);
                    axis_next  = AXIS_X;
                    sat_next   = 1'b0;
                    state_next = B_SETUP;
                end
            end
            B_SETUP:
            begin
                den_next   = DEN_W'(range_sel) + DEN_W'({range_sel, 1'b0});
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                // Quotient cannot fit (or range is zero): saturate this axis
                if (hi_ext >= den_ext)
                begin
                    gain_wr  = 1'b1;
                    gain_val = GAIN_MAX;
                    sat_next = 1'b1;
                    advance  = 1'b1;
                end
                else
                begin
                    rem_next   = hi_ext[DEN_W-1:0];
                    quo_next   = num[GAIN_BITS-1:0];
                    cnt_next   = '0;
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                rem_next = trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
                quo_next = {quo_reg[GAIN_BITS-2:0], trial_ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(GAIN_BITS - 1))
                begin
                    gain_wr  = 1'b1;
                    gain_val = {quo_reg[GAIN_BITS-2:0], trial_ge};
                    advance  = 1'b1;
                end
            end
            B_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    ox_next        = item_reg.offset_x;
                    oy_next        = item_reg.offset_y;
                    oz_next        = item_reg.offset_z;
                    ogx_next       = gx_reg;
                    ogy_next       = gy_reg;
                    ogz_next       = gz_reg;
                    osat_next      = sat_reg;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (advance)
        begin
            if (axis_reg == AXIS_Z)
            begin
                state_next = B_DONE;
            end
            else
            begin
                axis_next  = axis_t'(axis_reg + 2'd1);
                state_next = B_SETUP;
            end
        end
    end

    always_comb
    begin
        gx_next = gx_reg;
        gy_next = gy_reg;
        gz_next = gz_reg;
        if (gain_wr)
        begin
            unique case (axis_reg)
                AXIS_X:  gx_next = gain_val;
                AXIS_Y:  gy_next = gain_val;
                AXIS_Z:  gz_next = gain_val;
                default: gx_next = gain_val;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            axis_reg      <= AXIS_X;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        sum_reg  <= sum_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        sat_reg  <= sat_next;
        gx_reg   <= gx_next;
        gy_reg   <= gy_next;
        gz_reg   <= gz_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        oz_reg   <= oz_next;
        ogx_reg  <= ogx_next;
        ogy_reg  <= ogy_next;
        ogz_reg  <= ogz_next;
        osat_reg <= osat_next;
    end

    assign out_valid      = out_valid_reg;
    assign offset_x       = ox_reg;
    assign offset_y       = oy_reg;
    assign offset_z       = oz_reg;
    assign gain_x         = ogx_reg;
    assign gain_y         = ogy_reg;
    assign gain_z         = ogz_reg;
    assign gain_saturated = osat_reg;

endmodule

@@ hdl/magnetometer_minmax_calibration_core.sv @@
// Top level of the magnetometer min/max calibration core.
// Depends on mmc_pkg, mmc_front, mmc_fifo and mmc_back.
//
// Channel | Handshake            | Payload
// --------+----------------------+---------------------------------------------
// input   | in_valid / in_ready  | mag_x, mag_y, mag_z (signed samples)
// output  | out_valid / out_ready| offset_x/y/z, gain_x/y/z, gain_saturated
//
// Each transaction passes through the back end in order: a pop, then per
// axis a setup, an overflow check and the divide steps of the shared restoring
// divider, one per gain bit, then the load of the output register. An axis
// that saturates at the check skips its divide steps. The divider sets the rate.
// The front end takes a sample in the same cycle it arrives, as long as the
// two-entry queue has room, so up to two samples wait behind the divider.
// Reset clears all peaks to zero and empties the queue; no clearing pass.
// A stalled output holds its result while the back end works on the next.
module magnetometer_minmax_calibration_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mmc_pkg::sample_t  mag_x,
    input  mmc_pkg::sample_t  mag_y,
    input  mmc_pkg::sample_t  mag_z,
    output logic              out_valid,
    input  logic              out_ready,
    output mmc_pkg::sample_t  offset_x,
    output mmc_pkg::sample_t  offset_y,
    output mmc_pkg::sample_t  offset_z,
    output mmc_pkg::gain_t    gain_x,
    output mmc_pkg::gain_t    gain_y,
    output mmc_pkg::gain_t    gain_z,
    output logic              gain_saturated
);
    import mmc_pkg::*;

    // Front end to queue
    logic      push_valid, push_ready;
    mmc_item_t push_item;

    // Queue to back end
    logic      pop_valid, pop_ready;
    mmc_item_t pop_item;

    // Track peaks and derive offsets and ranges at accept time
    mmc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mag_x      (mag_x),
        .mag_y      (mag_y),
        .mag_z      (mag_z),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Decouple sample intake from the slow gain computation
    mmc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Divide per axis, saturate, and hold the result for the consumer
    mmc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_item       (pop_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .offset_x       (offset_x),
        .offset_y       (offset_y),
        .offset_z       (offset_z),
        .gain_x         (gain_x),
        .gain_y         (gain_y),
        .gain_z         (gain_z),
        .gain_saturated (gain_saturated)
    );

endmodule

@@ test/tb_magnetometer_minmax_calibration_core.sv @@
// Testbench for magnetometer_minmax_calibration_core: random and directed
// samples, with an in-bench calibration predictor checked field by field.
// Depends on mmc_pkg and the core RTL only.
module tb_magnetometer_minmax_calibration_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mmc_pkg::*;

    // Quiet cycles allowed before the run is declared hung. The longest
    // legal quiet stretch is the deliberate receiver hold-off below.
    localparam int WATCHDOG_LIMIT  = 4000;
    // Cycles to linger after the last result, well above the back-end latency.
    localparam int DRAIN_CYCLES    = 200;
    localparam int RANDOM_SAMPLES  = 735;
    // Receiver hold-off: long enough to fill the queue, the divider and the
    // output register so that in_ready drops.
    localparam int HOLD_OFF_AFTER  = 60;
    localparam int HOLD_OFF_CYCLES = 800;

    typedef enum int {
        RX_ALWAYS,
        RX_PATTERN,
        RX_RANDOM,
        RX_SLOW
    } rx_mode_t;

    typedef struct {
        sample_t x;
        sample_t y;
        sample_t z;
    } mag_sample_t;

    typedef struct packed {
        sample_t [2:0] offset;
        gain_t   [2:0] gain;
        logic          saturated;
    } cal_result_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    sample_t mag_x = '0;
    sample_t mag_y = '0;
    sample_t mag_z = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    sample_t offset_x;
    sample_t offset_y;
    sample_t offset_z;
    gain_t   gain_x;
    gain_t   gain_y;
    gain_t   gain_z;
    logic    gain_saturated;

    magnetometer_minmax_calibration_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mag_x          (mag_x),
        .mag_y          (mag_y),
        .mag_z          (mag_z),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .offset_x       (offset_x),
        .offset_y       (offset_y),
        .offset_z       (offset_z),
        .gain_x         (gain_x),
        .gain_y         (gain_y),
        .gain_z         (gain_z),
        .gain_saturated (gain_saturated)
    );

    // Stimulus waiting to be driven, and calibration results still owed.
    mag_sample_t pending_samples [$];
    cal_result_t expected_cal [$];

    // Predictor copy of the running per-axis peaks; reset leaves them at zero.
    int peak_hi [3] = '{0, 0, 0};
    int peak_lo [3] = '{0, 0, 0};

    int          total_samples = 0;
    int          samples_accepted = 0;
    int          results_seen = 0;
    int          error_count = 0;
    int          idle_cycles = 0;

    // Sender burst state.
    int          burst_left = 0;
    int          gap_left = 0;
    mag_sample_t next_sample;

    // Receiver stall state.
    rx_mode_t    rx_mode = RX_ALWAYS;
    int          mode_left = 0;
    logic [7:0]  stall_pattern = 8'b1011_0010;
    int          hold_off_left = 0;
    logic        hold_off_done = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Widen the peaks with one sample and work out the offsets and gains.
    // Offset is floor((max+min)/2); gain is sum of ranges over 3*range in
    // Q4.12, floored, pinned to full scale when the range is zero or the
    // quotient does not fit in 16 bits.
    function automatic cal_result_t calibrate_sample(input sample_t sx, input sample_t sy,
                                                     input sample_t sz);
        sample_t     axis_val [3];
        int          span [3];
        int          span_sum;
        longint      quotient;
        cal_result_t res;
        axis_val[0] = sx;
        axis_val[1] = sy;
        axis_val[2] = sz;
        span_sum = 0;
        res.saturated = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            if (axis_val[a] > peak_hi[a])
                peak_hi[a] = axis_val[a];
            if (axis_val[a] < peak_lo[a])
                peak_lo[a] = axis_val[a];
            span[a] = peak_hi[a] - peak_lo[a];
            span_sum += span[a];
            // Arithmetic shift of a signed int floors toward minus infinity.
            res.offset[a] = sample_t'((peak_hi[a] + peak_lo[a]) >>> 1);
        end
        for (int a = 0; a < 3; a++)
        begin
            if (span[a] == 0)
            begin
                res.gain[a] = GAIN_MAX;
                res.saturated = 1'b1;
            end
            else
            begin
                quotient = (longint'(span_sum) << GAIN_FRAC_BITS) / (3 * longint'(span[a]));
                if (quotient > longint'(GAIN_MAX))
                begin
                    res.gain[a] = GAIN_MAX;
                    res.saturated = 1'b1;
                end
                else
                begin
                    res.gain[a] = gain_t'(quotient);
                end
            end
        end
        return res;
    endfunction

    task automatic push_sample(input int x, input int y, input int z);
        mag_sample_t s;
        s.x = sample_t'(x);
        s.y = sample_t'(y);
        s.z = sample_t'(z);
        pending_samples.push_back(s);
    endtask

    // Draw one axis value within +/-bound: mostly uniform, sometimes right on
    // the bound to push a peak, sometimes near-zero noise that moves nothing.
    function automatic int draw_axis(input int bound);
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return int'($urandom_range(0, 2)) - 1;
        if (pick == 1)
            return ($urandom_range(0, 1) != 0) ? bound : -bound;
        return int'($urandom_range(0, 2 * bound)) - bound;
    endfunction

    task automatic check_field(input string field, input logic signed [31:0] want_v,
                               input logic signed [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
            error_count++;
        end
    endtask

    // Driver: advance to the next sample only when the current transaction
    // is taken or the channel is empty, so valid and payload hold otherwise.
    // Predict each accepted sample here, in the order the core receives them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mag_x    <= '0;
            mag_y    <= '0;
            mag_z    <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_cal.push_back(calibrate_sample(mag_x, mag_y, mag_z));
                samples_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    next_sample = pending_samples.pop_front();
                    mag_x    <= next_sample.x;
                    mag_y    <= next_sample.y;
                    mag_z    <= next_sample.z;
                    in_valid <= 1'b1;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        // Close the burst: half the time no gap at all, else a
                        // short one or one long enough to straddle a divide.
                        burst_left = $urandom_range(1, 12);
                        case ($urandom_range(0, 3))
                            0, 1:    gap_left = 0;
                            2:       gap_left = $urandom_range(1, 4);
                            default: gap_left = $urandom_range(20, 120);
                        endcase
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: switch between stall modes at random intervals, and once,
    // early in the run, hold out_ready low long enough to back up the input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_off_left > 0)
        begin
            hold_off_left--;
            out_ready <= 1'b0;
        end
        else if (!hold_off_done && results_seen >= HOLD_OFF_AFTER)
        begin
            hold_off_done = 1'b1;
            hold_off_left = HOLD_OFF_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 400);
            end
            else
            begin
                mode_left--;
            end
            case (rx_mode)
                RX_ALWAYS:  out_ready <= 1'b1;
                RX_PATTERN:
                begin
                    out_ready <= stall_pattern[0];
                    stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
                end
                RX_RANDOM:  out_ready <= ($urandom_range(0, 1) != 0);
                default:    out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Monitor: compare each taken result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_cal.size() == 0)
            begin
                $error("result transaction with no sample outstanding");
                error_count++;
            end
            else
            begin
                check_field("offset_x", expected_cal[0].offset[0], offset_x);
                check_field("offset_y", expected_cal[0].offset[1], offset_y);
                check_field("offset_z", expected_cal[0].offset[2], offset_z);
                check_field("gain_x", expected_cal[0].gain[0], gain_x);
                check_field("gain_y", expected_cal[0].gain[1], gain_y);
                check_field("gain_z", expected_cal[0].gain[2], gain_z);
                check_field("gain_saturated", expected_cal[0].saturated, gain_saturated);
                void'(expected_cal.pop_front());
            end
            results_seen++;
        end
    end

    // Watchdog: count cycles in which neither channel moves a transaction.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_magnetometer_minmax_calibration_core: errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int bound_x;
        int bound_y;
        int bound_z;

        // Opening directed samples, taken while the peaks are still small:
        // every axis range zero, then one axis at a time leaving zero.
        push_sample(0, 0, 0);
        push_sample(1, 0, 0);
        push_sample(0, -1, 0);
        // All ranges one: unity gain, negative odd sums floor downward.
        push_sample(0, 0, -1);
        push_sample(-1, 2, 1);
        // Large X range against tiny Z range: Z scale overflows.
        push_sample(100, 0, 0);
        push_sample(-3, 0, 0);
        push_sample(0, 1000, 0);
        push_sample(0, 0, 3);
        push_sample(0, -7, 0);

        // Random part: let each axis bound grow at its own pace (X linear,
        // Y square, Z cubic) so ratios sweep from overflow toward unity
        // instead of saturating the peaks in the first few samples.
        for (int i = 0; i < RANDOM_SAMPLES; i++)
        begin
            bound_x = 16 + i * 45;
            bound_y = 4 + (i * i) / 17;
            bound_z = i / 4 + (i * i * i) / 13000;
            if (bound_x > 32767)
                bound_x = 32767;
            if (bound_y > 32767)
                bound_y = 32767;
            if (bound_z > 32767)
                bound_z = 32767;
            push_sample(draw_axis(bound_x), draw_axis(bound_y), draw_axis(bound_z));
        end

        // Closing directed samples: full-scale extremes and alternating bits.
        push_sample(32767, -32768, 21845);
        push_sample(-32768, 32767, -21846);
        push_sample(0, 0, -32768);
        push_sample(0, 0, 32767);
        push_sample(-1, 1, 0);

        total_samples = pending_samples.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (samples_accepted < total_samples)
            @(posedge clk);
        while (expected_cal.size() != 0)
            @(posedge clk);
        // Linger so that any stray extra result gets caught by the monitor.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb_magnetometer_minmax_calibration_core: clean");
        else
            $display("tb_magnetometer_minmax_calibration_core: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/mmc_pkg.sv
hdl/mmc_front.sv
hdl/mmc_fifo.sv
hdl/mmc_back.sv
hdl/magnetometer_minmax_calibration_core.sv
test/tb_magnetometer_minmax_calibration_core.sv
